FILE: sv/fdgc_pkg.sv
// Package for the triangle deformation-gradient operator block.
// Holds the widths of the internal values and the signed value types.
// No dependencies.
package fdgc_pkg;

   localparam int unsigned CoordW = 32;
   localparam int unsigned EdgeW  = 33;
   localparam int unsigned CrossW = 67;
   localparam int unsigned SqW    = 136;
   localparam int unsigned LenW   = 68;
   localparam int unsigned NormW  = 32;
   localparam int unsigned AdjW   = 67;
   localparam int unsigned DetW   = 101;

   typedef logic signed [EdgeW-1:0]  edge_type;
   typedef logic signed [CrossW-1:0] cross_type;
   typedef logic signed [NormW-1:0]  norm_type;
   typedef logic signed [DetW-1:0]   det_type;
   typedef logic signed [AdjW-1:0]   adj_type;
   typedef logic signed [CoordW-1:0] coef_type;

endpackage

FILE: sv/face_deformation_gradient_coefs.sv
// Top level of the triangle deformation-gradient operator block.
// Uses fdgc_pkg, fdgc_sqrt and fdgc_pipe.
//
// Usage:
//  - Request channel (req_*): the nine Q16.16 corner coordinates of a triangle,
//    taken when req_valid is high and req_stall is low.
//  - Response channel (rsp_*): the twelve Q16.16 operator coefficients, taken
//    when rsp_valid is high and rsp_stall is low. One response per request,
//    in order.
//  - Throughput: one request per cycle. The whole datapath is a single pipeline
//    that moves only when its last stage is empty or being taken.
//  - Pipeline: six front stages (edges, cross terms, cross product, square
//    partials, squares, sum), 35 in the square root, 18 in each of the two
//    chained dividers, two product stages between them and the output register.
//  - A degenerate triangle (zero normal or zero determinant) gives all zeros.
//  - Reset clears every valid bit; payload registers are not cleared.
//  - When the receiver stalls, the pipeline freezes in place; req_stall rises
//    as soon as the output register is full and stalled, so nothing is lost
//    or repeated.
module face_deformation_gradient_coefs import fdgc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  coef_type req_c0_x, input coef_type req_c0_y, input coef_type req_c0_z,
   input  coef_type req_c1_x, input coef_type req_c1_y, input coef_type req_c1_z,
   input  coef_type req_c2_x, input coef_type req_c2_y, input coef_type req_c2_z,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output coef_type rsp_k_r0_c0, output coef_type rsp_k_r0_c1,
   output coef_type rsp_k_r0_c2, output coef_type rsp_k_r0_c3,
   output coef_type rsp_k_r1_c0, output coef_type rsp_k_r1_c1,
   output coef_type rsp_k_r1_c2, output coef_type rsp_k_r1_c3,
   output coef_type rsp_k_r2_c0, output coef_type rsp_k_r2_c1,
   output coef_type rsp_k_r2_c2, output coef_type rsp_k_r2_c3
);
   // Global advance: hold everything while the output is full and stalled.
   logic advance;
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   // Stage A: edges.
   logic     a_v_ff;
   edge_type e1_ff [3], e2_ff [3];
   always_ff @(posedge clock) begin
      if (reset) a_v_ff <= 1'b0;
      else if (advance) a_v_ff <= req_valid;
      if (advance) begin
         e1_ff[0] <= EdgeW'(req_c1_x) - EdgeW'(req_c0_x);
         e1_ff[1] <= EdgeW'(req_c1_y) - EdgeW'(req_c0_y);
         e1_ff[2] <= EdgeW'(req_c1_z) - EdgeW'(req_c0_z);
         e2_ff[0] <= EdgeW'(req_c2_x) - EdgeW'(req_c0_x);
         e2_ff[1] <= EdgeW'(req_c2_y) - EdgeW'(req_c0_y);
         e2_ff[2] <= EdgeW'(req_c2_z) - EdgeW'(req_c0_z);
      end
   end

   // Stage B: cross-product terms (six 33x33 products).
   logic      b_v_ff;
   edge_type  be1_ff [3], be2_ff [3];
   cross_type pp_ff [6];
   always_ff @(posedge clock) begin
      if (reset) b_v_ff <= 1'b0;
      else if (advance) b_v_ff <= a_v_ff;
      if (advance) begin
         be1_ff <= e1_ff;
         be2_ff <= e2_ff;
         pp_ff[0] <= CrossW'(e1_ff[1] * e2_ff[2]);
         pp_ff[1] <= CrossW'(e1_ff[2] * e2_ff[1]);
         pp_ff[2] <= CrossW'(e1_ff[2] * e2_ff[0]);
         pp_ff[3] <= CrossW'(e1_ff[0] * e2_ff[2]);
         pp_ff[4] <= CrossW'(e1_ff[0] * e2_ff[1]);
         pp_ff[5] <= CrossW'(e1_ff[1] * e2_ff[0]);
      end
   end

   // Stage C: cross product.
   logic      c_v_ff;
   edge_type  ce1_ff [3], ce2_ff [3];
   cross_type cr_ff [3];
   always_ff @(posedge clock) begin
      if (reset) c_v_ff <= 1'b0;
      else if (advance) c_v_ff <= b_v_ff;
      if (advance) begin
         ce1_ff <= be1_ff;
         ce2_ff <= be2_ff;
         cr_ff[0] <= pp_ff[0] - pp_ff[1];
         cr_ff[1] <= pp_ff[2] - pp_ff[3];
         cr_ff[2] <= pp_ff[4] - pp_ff[5];
      end
   end

   typedef struct packed {
      edge_type  e1x, e1y, e1z, e2x, e2y, e2z;
      cross_type cx, cy, cz;
   } geo_type;

   // Stage D: partial products of the squares. Split each cross component
   // into a signed high part and an unsigned low part of SplitW bits.
   localparam int unsigned SplitW = 34;
   logic               d_v_ff;
   edge_type           de1_ff [3], de2_ff [3];
   cross_type          dcr_ff [3];
   logic [65:0]        hh_ff [3];
   logic signed [67:0] hl_ff [3];
   logic [67:0]        ll_ff [3];
   always_ff @(posedge clock) begin
      if (reset) d_v_ff <= 1'b0;
      else if (advance) d_v_ff <= c_v_ff;
      if (advance) begin
         de1_ff <= ce1_ff;
         de2_ff <= ce2_ff;
         dcr_ff <= cr_ff;
         for (int i = 0; i < 3; i++) begin
            hh_ff[i] <= 66'($signed(cr_ff[i][CrossW-1:SplitW])
                            * $signed(cr_ff[i][CrossW-1:SplitW]));
            hl_ff[i] <= 68'($signed(cr_ff[i][CrossW-1:SplitW])
                            * $signed({1'b0, cr_ff[i][SplitW-1:0]}));
            ll_ff[i] <= 68'(cr_ff[i][SplitW-1:0] * cr_ff[i][SplitW-1:0]);
         end
      end
   end

   // Stage Q: squares, hi^2 * 2^68 + 2 * hi * lo * 2^34 + lo^2.
   logic           q_v_ff;
   geo_type        qg_ff;
   logic [SqW-1:0] sq_ff [3];
   always_ff @(posedge clock) begin
      if (reset) q_v_ff <= 1'b0;
      else if (advance) q_v_ff <= d_v_ff;
      if (advance) begin
         qg_ff <= '{de1_ff[0], de1_ff[1], de1_ff[2], de2_ff[0], de2_ff[1], de2_ff[2],
                    dcr_ff[0], dcr_ff[1], dcr_ff[2]};
         for (int i = 0; i < 3; i++)
            sq_ff[i] <= {2'b00, hh_ff[i], 68'b0}
                        + {{33{hl_ff[i][67]}}, hl_ff[i], 35'b0}
                        + {68'b0, ll_ff[i]};
      end
   end

   // Stage E: |c|^2.
   logic           e_v_ff;
   logic [SqW-1:0] s_ff;
   geo_type        eg_ff;
   always_ff @(posedge clock) begin
      if (reset) e_v_ff <= 1'b0;
      else if (advance) e_v_ff <= q_v_ff;
      if (advance) begin
         s_ff  <= sq_ff[0] + sq_ff[1] + sq_ff[2];
         eg_ff <= qg_ff;
      end
   end

   // Square root of |c|^2.
   logic            r_v;
   logic [LenW-1:0] r_len;
   geo_type         r_g;
   fdgc_sqrt #(.TagW($bits(geo_type))) u_sqrt (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(e_v_ff), .in_s(s_ff), .in_tag(eg_ff),
      .out_valid(r_v), .out_root(r_len), .out_tag(r_g)
   );

   // Normal: three divisions c_i * 2^16 / len.
   localparam int unsigned NNumW = CrossW + 16;
   localparam int unsigned NDenW = LenW + 1;
   cross_type r_c [3];
   assign r_c[0] = r_g.cx;
   assign r_c[1] = r_g.cy;
   assign r_c[2] = r_g.cz;
   logic      n_v [3];
   coef_type  n_q [3];
   geo_type   n_g [3];
   for (genvar i = 0; i < 3; i++) begin : g_norm
      fdgc_pipe #(.NumW(NNumW), .DenW(NDenW), .TagW($bits(geo_type))) u_div (
         .clock(clock), .reset(reset), .advance(advance),
         .in_valid(r_v), .in_num({r_c[i], 16'b0}),
         .in_den($signed({1'b0, r_len})), .in_tag(r_g),
         .out_valid(n_v[i]), .out_q(n_q[i]), .out_tag(n_g[i])
      );
   end

   // Stage F: products for det (each n_i * c_i split at bit SplitW of c_i)
   // and the adjugate rows (32x33 each).
   logic               f_v_ff;
   geo_type            fg_ff;
   logic signed [64:0] dh_ff [3];
   logic signed [66:0] dl_ff [3];
   adj_type            ap_ff [12];
   always_ff @(posedge clock) begin
      if (reset) f_v_ff <= 1'b0;
      else if (advance) f_v_ff <= n_v[0];
      if (advance) begin
         fg_ff <= n_g[0];
         dh_ff[0] <= 65'(n_q[0] * $signed(n_g[0].cx[CrossW-1:SplitW]));
         dh_ff[1] <= 65'(n_q[1] * $signed(n_g[0].cy[CrossW-1:SplitW]));
         dh_ff[2] <= 65'(n_q[2] * $signed(n_g[0].cz[CrossW-1:SplitW]));
         dl_ff[0] <= 67'(n_q[0] * $signed({1'b0, n_g[0].cx[SplitW-1:0]}));
         dl_ff[1] <= 67'(n_q[1] * $signed({1'b0, n_g[0].cy[SplitW-1:0]}));
         dl_ff[2] <= 67'(n_q[2] * $signed({1'b0, n_g[0].cz[SplitW-1:0]}));
         // e2 x n
         ap_ff[0]  <= AdjW'(n_g[0].e2y * n_q[2]);
         ap_ff[1]  <= AdjW'(n_g[0].e2z * n_q[1]);
         ap_ff[2]  <= AdjW'(n_g[0].e2z * n_q[0]);
         ap_ff[3]  <= AdjW'(n_g[0].e2x * n_q[2]);
         ap_ff[4]  <= AdjW'(n_g[0].e2x * n_q[1]);
         ap_ff[5]  <= AdjW'(n_g[0].e2y * n_q[0]);
         // n x e1
         ap_ff[6]  <= AdjW'(n_q[1] * n_g[0].e1z);
         ap_ff[7]  <= AdjW'(n_q[2] * n_g[0].e1y);
         ap_ff[8]  <= AdjW'(n_q[2] * n_g[0].e1x);
         ap_ff[9]  <= AdjW'(n_q[0] * n_g[0].e1z);
         ap_ff[10] <= AdjW'(n_q[0] * n_g[0].e1y);
         ap_ff[11] <= AdjW'(n_q[1] * n_g[0].e1x);
      end
   end

   // Stage G: det and adjugate, degenerate flag.
   logic    g_v_ff;
   det_type det_ff;
   adj_type adj_ff [9];
   logic    zero_ff;
   always_ff @(posedge clock) begin
      if (reset) g_v_ff <= 1'b0;
      else if (advance) g_v_ff <= f_v_ff;
      if (advance) begin
         det_ff <= (DetW'(dh_ff[0]) <<< SplitW) + DetW'(dl_ff[0])
                   + (DetW'(dh_ff[1]) <<< SplitW) + DetW'(dl_ff[1])
                   + (DetW'(dh_ff[2]) <<< SplitW) + DetW'(dl_ff[2]);
         zero_ff <= (fg_ff.cx == '0) && (fg_ff.cy == '0) && (fg_ff.cz == '0);
         adj_ff[0] <= ap_ff[0] - ap_ff[1];
         adj_ff[1] <= ap_ff[2] - ap_ff[3];
         adj_ff[2] <= ap_ff[4] - ap_ff[5];
         adj_ff[3] <= ap_ff[6] - ap_ff[7];
         adj_ff[4] <= ap_ff[8] - ap_ff[9];
         adj_ff[5] <= ap_ff[10] - ap_ff[11];
         adj_ff[6] <= fg_ff.cx;
         adj_ff[7] <= fg_ff.cy;
         adj_ff[8] <= fg_ff.cz;
      end
   end

   // Nine divisions adj * 2^32 / det. Index j*3+r holds adj[j][r].
   localparam int unsigned KNumW = AdjW + 32;
   logic     degen;
   assign degen = zero_ff || (det_ff == '0);
   logic     k_v [9];
   coef_type k_q [9];
   logic     k_z [9];
   for (genvar i = 0; i < 9; i++) begin : g_coef
      fdgc_pipe #(.NumW(KNumW), .DenW(DetW), .TagW(1)) u_div (
         .clock(clock), .reset(reset), .advance(advance),
         .in_valid(g_v_ff), .in_num({adj_ff[i], 32'b0}),
         .in_den(degen ? DetW'(1) : det_ff), .in_tag(degen),
         .out_valid(k_v[i]), .out_q(k_q[i]), .out_tag(k_z[i])
      );
   end

   // Output register: row sums and zeroing of degenerate triangles.
   logic     o_v_ff;
   coef_type k_ff [3][4];
   logic signed [CoordW+1:0] rsum [3];
   always_comb begin
      for (int r = 0; r < 3; r++)
         rsum[r] = -((CoordW+2)'(k_q[r]) + (CoordW+2)'(k_q[3+r]) + (CoordW+2)'(k_q[6+r]));
   end
   always_ff @(posedge clock) begin
      if (reset) o_v_ff <= 1'b0;
      else if (advance) o_v_ff <= k_v[0];
      if (advance) begin
         for (int r = 0; r < 3; r++) begin
            for (int j = 0; j < 3; j++)
               k_ff[r][j+1] <= k_z[0] ? '0 : k_q[j*3+r];
            if (k_z[0]) k_ff[r][0] <= '0;
            else if (rsum[r] > (CoordW+2)'(32'sh7fff_ffff)) k_ff[r][0] <= 32'sh7fff_ffff;
            else if (rsum[r] < -(CoordW+2)'(34'sh8000_0000)) k_ff[r][0] <= 32'sh8000_0000;
            else k_ff[r][0] <= coef_type'(rsum[r]);
         end
      end
   end

   assign rsp_valid = o_v_ff;
   assign rsp_k_r0_c0 = k_ff[0][0]; assign rsp_k_r0_c1 = k_ff[0][1];
   assign rsp_k_r0_c2 = k_ff[0][2]; assign rsp_k_r0_c3 = k_ff[0][3];
   assign rsp_k_r1_c0 = k_ff[1][0]; assign rsp_k_r1_c1 = k_ff[1][1];
   assign rsp_k_r1_c2 = k_ff[1][2]; assign rsp_k_r1_c3 = k_ff[1][3];
   assign rsp_k_r2_c0 = k_ff[2][0]; assign rsp_k_r2_c1 = k_ff[2][1];
   assign rsp_k_r2_c2 = k_ff[2][2]; assign rsp_k_r2_c3 = k_ff[2][3];

   // All lanes of the coefficient dividers move in lockstep.
   a_lanes: assert property (@(posedge clock) disable iff (reset)
      k_v[0] == k_v[8] && k_v[0] == k_v[4]) else $error("divider lanes out of step");
   // A stalled response stays put.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_k_r0_c0))
      else $error("response changed under stall");
   // Request side stalls exactly when the response is held.
   a_bp: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("backpressure mismatch");
endmodule

FILE: sv/fdgc_pipe.sv
// Pipelined shift-subtract unit: rounded, saturating signed division.
// Quotient bits are resolved two per stage; valid moves with the data.
// Depends on fdgc_pkg.
module fdgc_pipe import fdgc_pkg::*; #(
   parameter int unsigned NumW = 101,
   parameter int unsigned DenW = 101,
   parameter int unsigned TagW = 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   in_valid,
   input  logic signed [NumW-1:0] in_num,
   input  logic signed [DenW-1:0] in_den,
   input  logic [TagW-1:0]        in_tag,
   output logic                   out_valid,
   output coef_type               out_q,
   output logic [TagW-1:0]        out_tag
);
   // Need quotient bits up to 33 (saturation detect); a2 = 2|num|+|den|.
   localparam int unsigned AW = NumW + 2;
   localparam int unsigned BW = DenW + 1;
   localparam int unsigned QB = 34;
   localparam int unsigned PerStage = 2;
   localparam int unsigned NStage = QB / PerStage;

   typedef struct packed {
      logic [AW-1:0] rem;
      logic [QB-1:0] q;
      logic          big;
      logic          neg;
      logic [BW-1:0] b2;
      logic [TagW-1:0] tag;
   } st_type;

   st_type        st_ff [NStage+1];
   logic          v_ff  [NStage+1];

   logic [NumW-1:0] a_abs;
   logic [DenW-1:0] b_abs;
   logic [AW-1:0]   a2;

   always_comb begin
      a_abs = in_num[NumW-1] ? NumW'(-in_num) : NumW'(in_num);
      b_abs = in_den[DenW-1] ? DenW'(-in_den) : DenW'(in_den);
      a2 = {1'b0, a_abs, 1'b0} + AW'(b_abs);
   end

   // Stage 0: the high part of a2 above bit QB-1 must be less than b2,
   // otherwise the quotient overflows 34 bits (saturate).
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (advance) begin
         v_ff[0] <= in_valid;
      end
      if (advance) begin
         st_ff[0].rem <= AW'(a2 >> QB);
         st_ff[0].q   <= a2[QB-1:0];
         st_ff[0].big <= (AW'(a2 >> QB) >= AW'({b_abs, 1'b0}));
         st_ff[0].neg <= in_num[NumW-1] ^ in_den[DenW-1];
         st_ff[0].b2  <= {b_abs, 1'b0};
         st_ff[0].tag <= in_tag;
      end
   end

   for (genvar g = 0; g < NStage; g++) begin : g_stage
      st_type nx;
      always_comb begin
         nx = st_ff[g];
         for (int k = 0; k < PerStage; k++) begin
            nx.rem = {nx.rem[AW-2:0], nx.q[QB-1]};
            nx.q   = {nx.q[QB-2:0], 1'b0};
            if (nx.rem >= AW'(nx.b2)) begin
               nx.rem = nx.rem - AW'(nx.b2);
               nx.q[0] = 1'b1;
            end
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[g+1] <= 1'b0;
         end else if (advance) begin
            v_ff[g+1] <= v_ff[g];
         end
         if (advance) begin
            st_ff[g+1] <= nx;
         end
      end
   end

   logic          big;
   always_comb begin
      big = st_ff[NStage].big | (|st_ff[NStage].q[QB-1:31]);
      out_valid = v_ff[NStage];
      out_tag   = st_ff[NStage].tag;
      if (st_ff[NStage].neg) begin
         out_q = big ? coef_type'(32'sh8000_0000)
                     : coef_type'(-$signed({1'b0, st_ff[NStage].q[30:0]}));
      end else begin
         out_q = big ? coef_type'(32'sh7fff_ffff)
                     : coef_type'({1'b0, st_ff[NStage].q[30:0]});
      end
   end
endmodule

FILE: sv/fdgc_sqrt.sv
// Pipelined floor square root of a 136-bit value, two result bits per stage.
// Carries a payload alongside; valid travels with the data.
// Depends on fdgc_pkg.
module fdgc_sqrt import fdgc_pkg::*; #(
   parameter int unsigned TagW = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  logic [SqW-1:0]    in_s,
   input  logic [TagW-1:0]   in_tag,
   output logic              out_valid,
   output logic [LenW-1:0]   out_root,
   output logic [TagW-1:0]   out_tag
);
   localparam int unsigned PerStage = 2;
   localparam int unsigned NStage = LenW / PerStage;
   localparam int unsigned RW = LenW + 2;

   typedef struct packed {
      logic [SqW-1:0]  x;
      logic [RW-1:0]   rem;
      logic [LenW-1:0] root;
      logic [TagW-1:0] tag;
   } st_type;

   st_type st_ff [NStage+1];
   logic   v_ff  [NStage+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (advance) begin
         v_ff[0] <= in_valid;
      end
      if (advance) begin
         st_ff[0].x    <= in_s;
         st_ff[0].rem  <= '0;
         st_ff[0].root <= '0;
         st_ff[0].tag  <= in_tag;
      end
   end

   for (genvar g = 0; g < NStage; g++) begin : g_stage
      st_type nx;
      logic [RW-1:0] trial;
      always_comb begin
         nx = st_ff[g];
         trial = '0;
         for (int k = 0; k < PerStage; k++) begin
            // Bring down two radicand bits; try root*4+1.
            nx.rem = {nx.rem[RW-3:0], nx.x[SqW-1:SqW-2]};
            nx.x   = {nx.x[SqW-3:0], 2'b00};
            trial  = {nx.root, 2'b01};
            nx.root = {nx.root[LenW-2:0], 1'b0};
            if (nx.rem >= trial) begin
               nx.rem = nx.rem - trial;
               nx.root[0] = 1'b1;
            end
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[g+1] <= 1'b0;
         end else if (advance) begin
            v_ff[g+1] <= v_ff[g];
         end
         if (advance) begin
            st_ff[g+1] <= nx;
         end
      end
   end

   assign out_valid = v_ff[NStage];
   assign out_root  = st_ff[NStage].root;
   assign out_tag   = st_ff[NStage].tag;
endmodule

FILE: test/tb_top.sv
// Self-checking testbench for the triangle deformation-gradient operator block.
// Depends on fdgc_pkg and face_deformation_gradient_coefs; holds its own
// wide-integer predictor and a small scoreboard class.
`timescale 1ns / 1ps

module tb_top;
   import fdgc_pkg::*;

   // Wide signed integer for exact intermediate products.
   typedef logic signed [159:0] wide_t;
   typedef logic signed [31:0]  tri_t [9];

   typedef struct {
      coef_type k [12];
   } gradient_op_t;

   localparam int NumRandom = 1800;
   localparam int DrainCycles = 300;

   logic     clock;
   logic     reset;
   logic     req_valid;
   logic     req_stall;
   coef_type req_c [9];
   logic     rsp_valid;
   logic     rsp_stall;
   coef_type rsp_k [12];

   // Burst phases turn both sides' idling off for a while.
   bit       calm;

   face_deformation_gradient_coefs dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_c0_x    (req_c[0]), .req_c0_y (req_c[1]), .req_c0_z (req_c[2]),
      .req_c1_x    (req_c[3]), .req_c1_y (req_c[4]), .req_c1_z (req_c[5]),
      .req_c2_x    (req_c[6]), .req_c2_y (req_c[7]), .req_c2_z (req_c[8]),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_k_r0_c0 (rsp_k[0]), .rsp_k_r0_c1 (rsp_k[1]),
      .rsp_k_r0_c2 (rsp_k[2]), .rsp_k_r0_c3 (rsp_k[3]),
      .rsp_k_r1_c0 (rsp_k[4]), .rsp_k_r1_c1 (rsp_k[5]),
      .rsp_k_r1_c2 (rsp_k[6]), .rsp_k_r1_c3 (rsp_k[7]),
      .rsp_k_r2_c0 (rsp_k[8]), .rsp_k_r2_c1 (rsp_k[9]),
      .rsp_k_r2_c2 (rsp_k[10]), .rsp_k_r2_c3 (rsp_k[11])
   );

   // Quotient rounded to nearest, ties away from zero, clamped to 32 bits.
   function automatic coef_type div_round_sat(wide_t num, wide_t den);
      logic       neg;
      logic [159:0] a, b, q;
      logic       big;
      neg = num[159] ^ den[159];
      a = num[159] ? -num : num;
      b = den[159] ? -den : den;
      q = ((a << 1) + b) / (b << 1);
      big = (q >= 160'h8000_0000);
      if (neg) return big ? 32'sh8000_0000 : -coef_type'(q[31:0]);
      return big ? 32'sh7fff_ffff : coef_type'(q[31:0]);
   endfunction

   function automatic logic [159:0] floor_sqrt(logic [159:0] s);
      logic [159:0] r, t;
      r = '0;
      for (int i = 67; i >= 0; i--) begin
         t = r;
         t[i] = 1'b1;
         if (t * t <= s) r = t;
      end
      return r;
   endfunction

   function automatic void cross3(input wide_t a [3], input wide_t b [3],
                                  output wide_t o [3]);
      o[0] = a[1] * b[2] - a[2] * b[1];
      o[1] = a[2] * b[0] - a[0] * b[2];
      o[2] = a[0] * b[1] - a[1] * b[0];
   endfunction

   // Build the 3x4 operator of one triangle.
   function automatic gradient_op_t gradient_operator(tri_t p);
      gradient_op_t res;
      wide_t e1 [3], e2 [3], cr [3], nrm [3], adj0 [3], adj1 [3];
      wide_t sq, len, det;
      coef_type q;
      longint sum;
      foreach (res.k[i]) res.k[i] = '0;
      for (int i = 0; i < 3; i++) begin
         e1[i] = wide_t'(p[3+i]) - wide_t'(p[i]);
         e2[i] = wide_t'(p[6+i]) - wide_t'(p[i]);
      end
      cross3(e1, e2, cr);
      sq = cr[0] * cr[0] + cr[1] * cr[1] + cr[2] * cr[2];
      // Zero normal: all-zero operator.
      if (sq == 0) return res;
      len = wide_t'(floor_sqrt(sq));
      for (int i = 0; i < 3; i++) nrm[i] = wide_t'(div_round_sat(cr[i] <<< 16, len));
      det = nrm[0] * cr[0] + nrm[1] * cr[1] + nrm[2] * cr[2];
      if (det == 0) return res;
      cross3(e2, nrm, adj0);
      cross3(nrm, e1, adj1);
      for (int r = 0; r < 3; r++) begin
         sum = 0;
         q = div_round_sat(adj0[r] <<< 32, det);
         res.k[r*4+1] = q;
         sum += longint'(q);
         q = div_round_sat(adj1[r] <<< 32, det);
         res.k[r*4+2] = q;
         sum += longint'(q);
         q = div_round_sat(cr[r] <<< 32, det);
         res.k[r*4+3] = q;
         sum += longint'(q);
         sum = -sum;
         if (sum > 64'sd2147483647) sum = 64'sd2147483647;
         if (sum < -64'sd2147483648) sum = -64'sd2147483648;
         res.k[r*4] = coef_type'(sum[31:0]);
      end
      return res;
   endfunction

   class op_scoreboard;
      gradient_op_t pending [$];
      int errors;
      int checked;

      task report(string what, int idx, coef_type got, coef_type want);
         $display("MISMATCH %s result %0d field k_r%0d_c%0d: got %h want %h",
                  what, checked, idx / 4, idx % 4, got, want);
         errors++;
      endtask

      function void note_request(tri_t p);
         pending.push_back(gradient_operator(p));
      endfunction

      task check_response(coef_type got [12]);
         gradient_op_t want;
         if (pending.size() == 0) begin
            report("unexpected", 0, got[0], '0);
         end else begin
            want = pending.pop_front();
            for (int i = 0; i < 12; i++)
               if (got[i] !== want.k[i]) report("value", i, got[i], want.k[i]);
         end
         checked++;
      endtask
   endclass

   op_scoreboard board;
   int           directed_cnt;
   int           degenerate_cnt;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hold off a random number of cycles, then present one request and hold
   // it until accepted. Valid is only lowered when a gap is drawn.
   task send_triangle(tri_t p);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      for (int i = 0; i < 9; i++) req_c[i] <= p[i];
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      board.note_request(p);
      @(negedge clock);
   endtask

   function automatic logic signed [31:0] small_delta();
      int sh;
      logic signed [31:0] d;
      sh = $urandom_range(0, 20);
      d = $urandom_range(0, (1 << sh));
      return $urandom_range(0, 1) ? -d : d;
   endfunction

   function automatic tri_t random_triangle();
      tri_t p;
      int mode;
      int m;
      mode = $urandom_range(0, 9);
      for (int i = 0; i < 9; i++) p[i] = $urandom;
      case (mode)
         0, 1: begin
            // fully random corners
         end
         2: begin
            // collinear: c2 = c0 + m * (c1 - c0)
            m = $urandom_range(0, 4) - 2;
            for (int i = 0; i < 3; i++) begin
               p[3+i] = p[i] + small_delta();
               p[6+i] = p[i] + m * (p[3+i] - p[i]);
            end
         end
         3: begin
            // repeated corner
            for (int i = 0; i < 3; i++) p[3 + 3 * $urandom_range(0, 1) + i] = p[i];
         end
         4: begin
            // tiny triangle, coefficients saturate
            for (int i = 3; i < 9; i++) p[i] = p[i % 3] + $urandom_range(0, 6) - 3;
         end
         default: begin
            // ordinary mesh face near some corner
            for (int i = 3; i < 9; i++) p[i] = p[i % 3] + small_delta();
         end
      endcase
      return p;
   endfunction

   // Receiver: stall a random number of cycles, then take one response.
   initial begin
      int n;
      rsp_stall = 1'b1;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         n = calm ? 0 : $urandom_range(0, 10);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // Sample the response channel at the rising edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_response(rsp_k);
   end

   initial begin
      #20_000_000;
      $display("timeout with %0d responses outstanding", board.pending.size());
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      tri_t p;
      tri_t dir [$];
      int waited;
      board = new();
      calm = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      foreach (req_c[i]) req_c[i] = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed triangles: extremes, degenerate and saturating shapes.
      foreach (p[i]) p[i] = '0;
      dir.push_back(p);                                     // all corners equal
      p = '{0, 0, 0, 32'sh10000, 0, 0, 0, 32'sh10000, 0};
      dir.push_back(p);                                     // unit right triangle
      p = '{0, 0, 0, 0, 0, 32'sh10000, 32'sh10000, 0, 0};
      dir.push_back(p);
      p = '{0, 0, 0, 32'sh10000, 32'sh10000, 0, 32'sh20000, 32'sh20000, 0};
      dir.push_back(p);                                     // collinear
      p = '{0, 0, 0, 1, 0, 0, 0, 1, 0};
      dir.push_back(p);                                     // tiny, saturates
      p = '{0, 0, 0, 1, 1, 1, 0, 0, 1};
      dir.push_back(p);
      foreach (p[i]) p[i] = 32'sh7fff_ffff;
      p[3] = 32'sh8000_0000; p[7] = 32'sh8000_0000;
      dir.push_back(p);                                     // huge edges
      foreach (p[i]) p[i] = 32'sh8000_0000;
      p[3] = 32'sh7fff_ffff; p[7] = 32'sh7fff_ffff; p[2] = 32'sh7fff_ffff;
      dir.push_back(p);
      p = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
            32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000,
            32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff};
      dir.push_back(p);
      p = '{-1, -1, -1, 0, 0, 0, 32'sh7fff_ffff, 32'sh8000_0000, 0};
      dir.push_back(p);
      p = '{32'sh30000, -32'sh20000, 32'sh5000, 32'sh30001, -32'sh20000, 32'sh5000,
            32'sh30000, -32'sh20000, 32'sh5001};
      dir.push_back(p);
      p = '{0, 0, 0, 32'sh1234_5678, -32'sh0765_4321, 32'sh0abc_def0,
            -32'sh0fed_cba9, 32'sh0246_8ace, 32'sh1357_9bdf};
      dir.push_back(p);
      p = '{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
            32'sh7fff_ffff, 32'sh7fff_fffe, 32'sh7fff_fffe, 32'sh7fff_ffff,
            32'sh7fff_ffff};
      dir.push_back(p);
      foreach (dir[i]) send_triangle(dir[i]);
      directed_cnt = dir.size();

      // Random triangles, with occasional stretches of back-to-back traffic.
      degenerate_cnt = 0;
      for (int i = 0; i < NumRandom; i++) begin
         if (i % 150 == 0) calm = ($urandom_range(0, 3) == 0);
         p = random_triangle();
         if (gradient_operator(p).k[3] == 0) degenerate_cnt++;
         send_triangle(p);
      end
      req_valid <= 1'b0;
      calm = 1'b0;

      waited = 0;
      while (board.pending.size() != 0 && waited < 100_000) begin
         @(posedge clock);
         waited++;
      end
      repeat (DrainCycles) @(posedge clock);

      $display("covered %0d directed and %0d random triangles, %0d responses checked",
               directed_cnt, NumRandom, board.checked);
      $display("about %0d random triangles had a zero or degenerate normal term",
               degenerate_cnt);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches, %0d responses missing", board.errors,
                  board.pending.size());
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
